// ===== hw/rtl/bpq_pkg.sv =====
// Shared types and constants for the bounded priority queue.
`default_nettype none

package bpq_pkg;

	localparam int BPQ_DEPTH     = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int PAYLOAD_BITS  = 32;
	localparam int FILL_W        = 5;

	typedef enum logic {
		CMD_INSERT  = 1'b0,
		CMD_EXTRACT = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [PRIORITY_BITS-1:0] prio;
		logic [PAYLOAD_BITS-1:0]  data;
	} entry_t;

	typedef struct packed {
		cmd_t                            cmd;
		logic [PRIORITY_BITS-1:0]        priority_req;
		logic signed [PAYLOAD_BITS-1:0]  payload;
	} req_t;

	typedef struct packed {
		status_t                         status;
		logic [PRIORITY_BITS-1:0]        out_priority;
		logic signed [PAYLOAD_BITS-1:0]  out_payload;
		logic [FILL_W-1:0]               fill_count;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bpq_mem.sv =====
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module bpq_mem import bpq_pkg::*; #(
	parameter int QUEUE_DEPTH = BPQ_DEPTH,
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);

	entry_t store_q [QUEUE_DEPTH];
	entry_t rdata_q;

	// write one entry, read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= store_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bpq_seq.sv =====
// Sequencer: insert, linear max scan with a shared compare, and gap compaction.
`default_nettype none

module bpq_seq import bpq_pkg::*; #(
	parameter int QUEUE_DEPTH = BPQ_DEPTH,
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire req_t          req,
	output logic               res_valid,
	input  wire logic          res_ready,
	output rsp_t               res,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output entry_t             mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	input  wire entry_t        mem_rdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

	localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

	state_t        state_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] issued_q;
	logic          rvalid_q;
	logic [CW-1:0] cmp_idx_q;
	logic [AW-1:0] cmp_addr_q;
	entry_t        best_q;
	logic [AW-1:0] best_idx_q;
	logic [AW-1:0] best_addr_q;
	logic [AW-1:0] src_ptr_q;
	logic [AW-1:0] dst_q;
	logic [AW-1:0] sh_left_q;
	logic          pend_q;
	logic [AW-1:0] pend_dst_q;
	rsp_t          res_q;

	logic          accept;
	logic          take;
	logic          scan_last;
	entry_t        nb_entry;
	logic [AW-1:0] nb_idx;
	logic [AW-1:0] nb_addr;

	function automatic logic [AW-1:0] inc_slot(input logic [AW-1:0] a);
		return (a == LAST_SLOT) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [AW-1:0] dec_slot(input logic [AW-1:0] a);
		return (a == '0) ? LAST_SLOT : a - 1'b1;
	endfunction

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign res_valid = (state_q == S_FINISH);
	assign res       = res_q;

	// shared compare: first entry seeds, strictly larger replaces (oldest wins ties)
	assign take      = (cmp_idx_q == '0) || (mem_rdata.prio > best_q.prio);
	assign scan_last = rvalid_q && (cmp_idx_q == count_q - 1'b1);
	assign nb_entry  = take ? mem_rdata : best_q;
	assign nb_idx    = take ? AW'(cmp_idx_q) : best_idx_q;
	assign nb_addr   = take ? cmp_addr_q : best_addr_q;

	// drive the store ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = '{prio: req.priority_req, data: req.payload};
		mem_re    = 1'b0;
		mem_raddr = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.cmd == CMD_INSERT && count_q != FULL_CNT) begin
					mem_we = 1'b1;
				end
				if (accept && req.cmd == CMD_EXTRACT && count_q != '0) begin
					mem_re = 1'b1;
				end
			end
			S_SCAN: begin
				if (issued_q < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = rd_ptr_q;
				end
			end
			S_SHIFT: begin
				if (sh_left_q != '0) begin
					mem_re    = 1'b1;
					mem_raddr = src_ptr_q;
				end
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = pend_dst_q;
					mem_wdata = mem_rdata;
				end
			end
			S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// state and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			issued_q    <= '0;
			rvalid_q    <= 1'b0;
			cmp_idx_q   <= '0;
			cmp_addr_q  <= '0;
			best_q      <= '0;
			best_idx_q  <= '0;
			best_addr_q <= '0;
			src_ptr_q   <= '0;
			dst_q       <= '0;
			sh_left_q   <= '0;
			pend_q      <= 1'b0;
			pend_dst_q  <= '0;
			res_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q <= '0;
						if (req.cmd == CMD_INSERT) begin
							state_q <= S_FINISH;
							if (count_q == FULL_CNT) begin
								res_q.status     <= ST_FULL;
								res_q.fill_count <= FILL_W'(count_q);
							end else begin
								tail_q           <= inc_slot(tail_q);
								count_q          <= count_q + 1'b1;
								res_q.status     <= ST_DONE;
								res_q.fill_count <= FILL_W'(count_q + 1'b1);
							end
						end else if (count_q == '0) begin
							state_q      <= S_FINISH;
							res_q.status <= ST_EMPTY;
						end else begin
							// first read of the scan goes out now
							state_q    <= S_SCAN;
							rd_ptr_q   <= inc_slot(head_q);
							issued_q   <= CW'(1);
							rvalid_q   <= 1'b1;
							cmp_idx_q  <= '0;
							cmp_addr_q <= head_q;
						end
					end
				end
				S_SCAN: begin
					// advance the read pointer
					if (issued_q < count_q) begin
						rd_ptr_q   <= inc_slot(rd_ptr_q);
						issued_q   <= issued_q + 1'b1;
						rvalid_q   <= 1'b1;
						cmp_addr_q <= rd_ptr_q;
					end else begin
						rvalid_q <= 1'b0;
					end
					// compare the returning entry
					if (rvalid_q) begin
						cmp_idx_q   <= cmp_idx_q + 1'b1;
						best_q      <= nb_entry;
						best_idx_q  <= nb_idx;
						best_addr_q <= nb_addr;
					end
					if (scan_last) begin
						head_q             <= inc_slot(head_q);
						count_q            <= count_q - 1'b1;
						res_q.status       <= ST_DONE;
						res_q.out_priority <= nb_entry.prio;
						res_q.out_payload  <= nb_entry.data;
						res_q.fill_count   <= FILL_W'(count_q - 1'b1);
						rvalid_q           <= 1'b0;
						if (nb_idx == '0) begin
							state_q <= S_FINISH;
						end else begin
							state_q   <= S_SHIFT;
							src_ptr_q <= dec_slot(nb_addr);
							dst_q     <= nb_addr;
							sh_left_q <= nb_idx;
							pend_q    <= 1'b0;
						end
					end
				end
				S_SHIFT: begin
					// move older entries one slot toward the tail
					if (sh_left_q != '0) begin
						src_ptr_q  <= dec_slot(src_ptr_q);
						sh_left_q  <= sh_left_q - 1'b1;
						pend_q     <= 1'b1;
						pend_dst_q <= dst_q;
						dst_q      <= src_ptr_q;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && sh_left_q == '0) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	a_scan_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (issued_q <= count_q))
		else $error("scan read past held entries");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_IDLE || state_q == S_SHIFT))
		else $error("store write outside insert or compaction");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd == CMD_INSERT && count_q != FULL_CNT)
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not bump count");

	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_EMPTY) |-> (count_q == '0))
		else $error("empty reported with entries held");

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_priority_queue_top.sv =====
// Top level of the bounded priority queue: sequencer, entry store, result register.
// Insert, full insert and empty extract: the result is registered in the sequencer, then in the output register.
// Extract scans the held entries oldest first, then shifts the older ones into the gap when
// the oldest does not win; both steps share the single read port of the store.
// One item at a time, the next beat taken once the result has moved to the output register.
// Reset clears pointers, count and handshakes; store contents stay undefined.
`default_nettype none

module bounded_priority_queue_top import bpq_pkg::*; #(
	parameter int QUEUE_DEPTH = BPQ_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic          res_valid;
	logic          res_ready;
	rsp_t          res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	bpq_seq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bpq_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// load the output beat when the register is empty or being drained
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
			if (res_valid) begin
				rsp_q <= res;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for the bounded priority queue: directed and random insert/extract traffic.
`default_nettype none

module tb;
	import bpq_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Mirror of the queue contents, kept in arrival order from head to tail
	entry_t mirror_slot [BPQ_DEPTH];
	int mirror_head = 0;
	int mirror_tail = 0;
	int mirror_held = 0;

	rsp_t pending_rsp [$];
	int err_count = 0;
	int src_hold_max = 8;
	int sink_hold_max = 8;
	int sink_hold_left = 0;

	bounded_priority_queue_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	// Run limit, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("tb: FAIL");
		$finish;
	end

	// Apply one request to the mirror and return the response it must produce
	function automatic rsp_t apply_queue_op(req_t r);
		rsp_t o;
		int best;
		o = '0;
		o.status = ST_DONE;
		if (r.cmd == CMD_INSERT) begin
			if (mirror_held >= BPQ_DEPTH) begin
				o.status = ST_FULL;
			end else begin
				mirror_slot[mirror_tail].prio = r.priority_req;
				mirror_slot[mirror_tail].data = r.payload;
				mirror_tail = (mirror_tail + 1) % BPQ_DEPTH;
				mirror_held++;
			end
		end else if (mirror_held == 0) begin
			o.status = ST_EMPTY;
		end else begin
			// scan oldest first; strict compare keeps the oldest on ties
			best = 0;
			for (int i = 1; i < mirror_held; i++) begin
				if (mirror_slot[(mirror_head + i) % BPQ_DEPTH].prio >
				    mirror_slot[(mirror_head + best) % BPQ_DEPTH].prio)
					best = i;
			end
			o.out_priority = mirror_slot[(mirror_head + best) % BPQ_DEPTH].prio;
			o.out_payload  = mirror_slot[(mirror_head + best) % BPQ_DEPTH].data;
			// close the gap: shift older entries one slot toward the tail
			for (int i = best; i > 0; i--)
				mirror_slot[(mirror_head + i) % BPQ_DEPTH] =
					mirror_slot[(mirror_head + i - 1) % BPQ_DEPTH];
			mirror_head = (mirror_head + 1) % BPQ_DEPTH;
			mirror_held--;
		end
		o.fill_count = mirror_held[FILL_W-1:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		err_count++;
		if (err_count <= 200)
			$display("tb: mismatch %s at %0t: got %0h, want %0h", what, $realtime, got, want);
	endtask

	// Check each result beat against the oldest prediction, then draw the next stall
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected result", 64'(rsp), '0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", 64'(rsp.status), 64'(want.status));
				if (rsp.out_priority !== want.out_priority)
					report_mismatch("out_priority", 64'(rsp.out_priority),
						64'(want.out_priority));
				if (rsp.out_payload !== want.out_payload)
					report_mismatch("out_payload", 64'(rsp.out_payload),
						64'(want.out_payload));
				if (rsp.fill_count !== want.fill_count)
					report_mismatch("fill_count", 64'(rsp.fill_count),
						64'(want.fill_count));
			end
			sink_hold_left = (sink_hold_max == 0) ? 0 : $urandom_range(sink_hold_max, 0);
		end
		if (sink_hold_left > 0) begin
			rsp_stall <= 1'b1;
			sink_hold_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Send one request beat after a random gap; record its prediction on acceptance
	task automatic send_beat(cmd_t c, logic [PRIORITY_BITS-1:0] p, logic [PAYLOAD_BITS-1:0] d);
		int gap;
		req_t item;
		gap = (src_hold_max == 0) ? 0 : $urandom_range(src_hold_max, 0);
		item.cmd = c;
		item.priority_req = p;
		item.payload = d;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall !== 1'b0);
		pending_rsp.push_back(apply_queue_op(item));
	endtask

	// Hold off the sender until every predicted result has come back
	task automatic wait_for_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	task automatic test_empty_extract();
		send_beat(CMD_EXTRACT, 8'hff, 32'hffff_ffff);
		send_beat(CMD_EXTRACT, 8'h00, 32'h0000_0000);
	endtask

	// Fill to capacity with extreme fields and repeated priorities, then overflow
	task automatic test_fill_to_full();
		logic [PRIORITY_BITS-1:0] prio_list [BPQ_DEPTH] = '{
			8'd0, 8'd255, 8'd7, 8'd255, 8'd128, 8'd1, 8'd255, 8'd0,
			8'd128, 8'd127, 8'd254, 8'd7, 8'd0, 8'd255, 8'd1, 8'd128};
		logic [PAYLOAD_BITS-1:0] data_list [4] = '{
			32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000};
		for (int i = 0; i < BPQ_DEPTH; i++)
			send_beat(CMD_INSERT, prio_list[i], data_list[i % 4] ^ i);
		send_beat(CMD_INSERT, 8'hff, 32'h7fff_ffff);
		wait_for_results();
	endtask

	// Drain part of the queue; equal top priorities must come out oldest first
	task automatic test_extract_order();
		repeat (5) send_beat(CMD_EXTRACT, 8'h00, 32'h0);
	endtask

	// Random blocks with varying insert bias, priority spread and handshake pressure
	task automatic test_random_mix();
		int insert_pct;
		int prio_style;
		logic [PRIORITY_BITS-1:0] p;
		for (int blk = 0; blk < 39; blk++) begin
			case ($urandom_range(3, 0))
				0: insert_pct = 20;
				1: insert_pct = 80;
				default: insert_pct = 50;
			endcase
			prio_style = $urandom_range(2, 0);
			src_hold_max = ($urandom_range(3, 0) == 0) ? 0 : 8;
			sink_hold_max = ($urandom_range(3, 0) == 0) ? 0 : 8;
			for (int n = 0; n < 50; n++) begin
				case (prio_style)
					0: p = PRIORITY_BITS'($urandom_range(255, 0));
					1: p = PRIORITY_BITS'($urandom_range(3, 0));
					default: p = $urandom_range(1, 0) ? 8'hff : 8'h00;
				endcase
				if ($urandom_range(99, 0) < insert_pct)
					send_beat(CMD_INSERT, p, $urandom);
				else
					send_beat(CMD_EXTRACT, p, $urandom);
			end
			if (blk % 8 == 7)
				wait_for_results();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_extract();
		test_fill_to_full();
		test_extract_order();
		test_random_mix();
		wait_for_results();
		// let any stray result beat show up before the verdict
		repeat (2 * BPQ_DEPTH + 8) @(posedge clk);
		if (err_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
